/* rtl/hbrq_pkg.sv */
// ----------------------------------------------------------------------------
// hbrq_pkg
// Shared widths, register indexes and defaults of the bin range query unit.
// ----------------------------------------------------------------------------
package hbrq_pkg;

  localparam int unsigned CoordW     = 63;
  localparam int unsigned WordW      = 64;
  localparam int unsigned PitchW     = 8;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned MaxDepthsDefault = 8;

  localparam logic [WordW-1:0] DepthMaskReset  = 64'd1;
  localparam logic [WordW-1:0] PitchTableReset = 64'd62;

  typedef enum logic [CfgIdxW-1:0] {
    RegDepthCountMask = 8'd0,
    RegPitchTable     = 8'd1
  } hbrq_reg_e;

endpackage

/* rtl/hbrq_ifs.sv */
// ----------------------------------------------------------------------------
// hbrq channel interfaces
// Query, result and configuration channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface hbrq_query_if;
  import hbrq_pkg::*;

  logic              valid;
  logic              ready;
  logic [CoordW-1:0] query_start;
  logic [CoordW-1:0] query_end;

  modport source (output valid, query_start, query_end, input ready);
  modport sink   (input valid, query_start, query_end, output ready);
endinterface

interface hbrq_result_if;
  import hbrq_pkg::*;

  logic              valid;
  logic              ready;
  logic [WordW-1:0]  slice_offset;
  logic [WordW-1:0]  slice_count;
  logic [CoordW-1:0] cover_start;
  logic [WordW-1:0]  cover_end;
  logic [WordW-1:0]  span_size;
  logic              empty_res;
  logic              depth_overflow;
  logic              last;

  modport source (output valid, slice_offset, slice_count, cover_start, cover_end,
                  span_size, empty_res, depth_overflow, last, input ready);
  modport sink   (input valid, slice_offset, slice_count, cover_start, cover_end,
                  span_size, empty_res, depth_overflow, last, output ready);
endinterface

interface hbrq_cfg_if;
  import hbrq_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [WordW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/hierarchical_bin_range_query_unit.sv */
// Each issued depth passes s1, s2, s3 and the output register; one result per cycle while the receiver is ready.
// A query holds the depth sequencer for max(1, min(set mask bits, MaxDepths, 8))
// issues, one mask bit per issue; the next query is taken with the last issue.
// A mask write reaches the overflow flag through mask_q, bytecnt_q and ovf_q.
// Reset: mask returns to 1, pitch table to 62, sequencer and pipeline empty.
// ----------------------------------------------------------------------------
// hierarchical_bin_range_query_unit
// Walks the depths of a half-overlapping bin hierarchy for one query range
// and delivers one bin table slice per depth through a four-stage pipeline.
// ----------------------------------------------------------------------------
module hierarchical_bin_range_query_unit #(
  parameter int unsigned MaxDepths = hbrq_pkg::MaxDepthsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  hbrq_cfg_if.sink      cfg_i,
  hbrq_query_if.sink    query_i,
  hbrq_result_if.source result_o
);
  import hbrq_pkg::*;

  localparam int unsigned Cap  = (MaxDepths < 8) ? MaxDepths : 8;
  localparam int unsigned IdxW = (Cap > 1) ? $clog2(Cap) : 1;

  typedef struct packed {
    logic [WordW-1:0]  base;
    logic [WordW-1:0]  nm1;
    logic [PitchW-1:0] p;
    logic [CoordW-1:0] qs;
    logic [CoordW-1:0] qe;
    logic              last;
    logic              empty;
  } s1_t;

  typedef struct packed {
    logic [WordW-1:0]  base;
    logic [WordW-1:0]  nm1;
    logic [PitchW-1:0] p;
    logic [CoordW-1:0] sr;
    logic [CoordW-1:0] tr;
    logic              last;
    logic              empty;
  } s2_t;

  typedef struct packed {
    logic [WordW-1:0]  base;
    logic [PitchW-1:0] p;
    logic [CoordW-1:0] s;
    logic [WordW-1:0]  e;
    logic [WordW-1:0]  ep1;
    logic              last;
    logic              empty;
  } s3_t;

  typedef struct packed {
    logic [WordW-1:0]  slice_offset;
    logic [WordW-1:0]  slice_count;
    logic [CoordW-1:0] cover_start;
    logic [WordW-1:0]  cover_end;
    logic [WordW-1:0]  span_size;
    logic              empty_res;
    logic              depth_overflow;
    logic              last;
  } res_t;

  function automatic logic [3:0] popcount8(logic [7:0] x);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'b0, x[i]};
    end
    return c;
  endfunction

  // configuration
  logic [WordW-1:0] mask_q, pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= DepthMaskReset;
      pitch_q <= PitchTableReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (hbrq_reg_e'(cfg_i.index))
        RegDepthCountMask: mask_q  <= cfg_i.data;
        RegPitchTable:     pitch_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // overflow flag, popcount of the mask over two stages
  logic [7:0][3:0] bytecnt_q;
  logic [6:0]      masksum;
  logic            ovf_q;

  always_comb begin
    masksum = '0;
    for (int i = 0; i < 8; i++) begin
      masksum = masksum + {3'b0, bytecnt_q[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytecnt_q <= '0;
      ovf_q     <= 1'b0;
    end else begin
      for (int i = 0; i < 8; i++) begin
        bytecnt_q[i] <= popcount8(mask_q[i*8 +: 8]);
      end
      ovf_q <= masksum > 7'(Cap);
    end
  end

  // depth sequencer
  logic              busy_q;
  logic [WordW-1:0]  rem_q;
  logic [IdxW-1:0]   idx_q;
  logic [CoordW-1:0] qs_q, qe_q;
  logic              out_vld_q;
  logic              adv, issue, last_issue, accept;
  logic [WordW-1:0]  rem_dec, below, rem_nxt;

  assign adv        = !out_vld_q || result_o.ready;
  assign issue      = busy_q && adv;
  assign rem_dec    = rem_q - 64'd1;
  assign below      = ~rem_q & rem_dec;
  assign rem_nxt    = rem_q & rem_dec;
  assign last_issue = (rem_nxt == '0) || (idx_q == IdxW'(Cap - 1));
  assign query_i.ready = !busy_q || (issue && last_issue);
  assign accept     = query_i.valid && query_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
      idx_q  <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      rem_q  <= mask_q;
      idx_q  <= '0;
    end else if (issue) begin
      busy_q <= !last_issue;
      rem_q  <= rem_nxt;
      idx_q  <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      qs_q <= query_i.query_start;
      qe_q <= query_i.query_end;
    end
  end

  // pipeline
  logic s1_vld_q, s2_vld_q, s3_vld_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  res_t out_d, out_q;
  logic [CoordW-1:0] tmin_lo;
  logic [WordW-1:0]  tmin, s_ext, s_shl;

  always_comb begin
    s1_d.base  = mask_q & below;
    s1_d.nm1   = below;
    s1_d.p     = pitch_q[idx_q*PitchW +: PitchW];
    s1_d.qs    = qs_q;
    s1_d.qe    = qe_q;
    s1_d.last  = last_issue;
    s1_d.empty = rem_q == '0;
  end

  always_comb begin
    s2_d.base  = s1_q.base;
    s2_d.nm1   = s1_q.nm1;
    s2_d.p     = s1_q.p;
    s2_d.sr    = s1_q.qs >> s1_q.p;
    s2_d.tr    = s1_q.qe >> s1_q.p;
    s2_d.last  = s1_q.last;
    s2_d.empty = s1_q.empty;
  end

  always_comb begin
    tmin_lo    = s2_q.tr;
    tmin       = ({1'b0, tmin_lo} > s2_q.nm1) ? s2_q.nm1 : {1'b0, tmin_lo};
    s3_d.base  = s2_q.base;
    s3_d.p     = s2_q.p;
    s3_d.s     = (s2_q.sr != '0) ? s2_q.sr - CoordW'(1) : s2_q.sr;
    s3_d.e     = tmin + 64'd1;
    s3_d.ep1   = tmin + 64'd2;
    s3_d.last  = s2_q.last;
    s3_d.empty = s2_q.empty;
  end

  always_comb begin
    s_ext = {1'b0, s3_q.s};
    s_shl = s_ext << s3_q.p;
    out_d.slice_offset   = s3_q.base + s_ext;
    out_d.slice_count    = (s3_q.e > s_ext) ? s3_q.e - s_ext : '0;
    out_d.cover_start    = s_shl[CoordW-1:0];
    out_d.cover_end      = s3_q.ep1 << s3_q.p;
    out_d.span_size      = 64'd2 << s3_q.p;
    out_d.empty_res      = s3_q.empty;
    out_d.depth_overflow = ovf_q;
    out_d.last           = s3_q.last;
    if (s3_q.empty) begin
      // zero mask: single empty result
      out_d.slice_offset = '0;
      out_d.slice_count  = '0;
      out_d.cover_start  = '0;
      out_d.cover_end    = '0;
      out_d.span_size    = '0;
      out_d.last         = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= issue;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      out_q <= out_d;
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.slice_offset   = out_q.slice_offset;
  assign result_o.slice_count    = out_q.slice_count;
  assign result_o.cover_start    = out_q.cover_start;
  assign result_o.cover_end      = out_q.cover_end;
  assign result_o.span_size      = out_q.span_size;
  assign result_o.empty_res      = out_q.empty_res;
  assign result_o.depth_overflow = out_q.depth_overflow;
  assign result_o.last           = out_q.last;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hierarchical bin range query unit testbench
// Sends query ranges through the valid/ready query channel under several
// mask and pitch settings and random idling on both sides. Every result
// slice is checked field by field against a local model of the depth walk.
// ----------------------------------------------------------------------------
module testbench;
  import hbrq_pkg::*;

  localparam int unsigned DepthCap    = 8;
  localparam int unsigned IdlePct     = 69;
  localparam int unsigned BothPct     = 10;
  localparam int unsigned PauseCycles = 12;
  localparam int unsigned MaxReports  = 40;
  localparam int unsigned CycleLimit  = 400000;

  typedef enum logic [1:0] {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct packed {
    logic [CoordW-1:0] query_start;
    logic [CoordW-1:0] query_end;
  } query_t;

  typedef struct packed {
    logic [WordW-1:0]  slice_offset;
    logic [WordW-1:0]  slice_count;
    logic [CoordW-1:0] cover_start;
    logic [WordW-1:0]  cover_end;
    logic [WordW-1:0]  span_size;
    logic              empty_res;
    logic              depth_overflow;
    logic              last;
  } slice_t;

  logic clk;
  logic rst_n;

  hbrq_cfg_if    cfg_if ();
  hbrq_query_if  query_if ();
  hbrq_result_if result_if ();

  hierarchical_bin_range_query_unit u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_if),
    .query_i (query_if),
    .result_o(result_if)
  );

  query_t       pending_queries[$];
  slice_t       slices_due[$];
  logic [63:0]  mask_cfg;
  logic [63:0]  pitch_cfg;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_cycles;
  int unsigned  errors;
  int unsigned  queries_taken;
  int unsigned  slices_checked;
  int unsigned  settings_used;
  int unsigned  cycle_count;
  query_t       next_item;
  slice_t       got_slice;
  slice_t       want_slice;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // expected slices of one query under the current mask and pitch table
  function automatic void predict_slices(logic [CoordW-1:0] q_start,
                                         logic [CoordW-1:0] q_end);
    logic [63:0] visited, remaining, lowbit, base, s, t, e, qs, qe;
    logic [7:0]  p;
    logic        ovf;
    slice_t      sl;
    qs  = 64'(q_start);
    qe  = 64'(q_end);
    ovf = $countones(mask_cfg) > DepthCap;
    sl  = '0;
    if (mask_cfg == '0) begin
      sl.empty_res = 1'b1;
      sl.last      = 1'b1;
      slices_due.push_back(sl);
      return;
    end
    visited = '0;
    for (int k = 0; k < DepthCap; k++) begin
      remaining = mask_cfg & ~visited;
      if (remaining == '0) break;
      lowbit = remaining & (~remaining + 64'd1);
      base   = mask_cfg & visited;
      p      = pitch_cfg[8*k +: 8];
      s = qs >> p;
      if (s != '0) s = s - 64'd1;
      t = qe >> p;
      if (t > lowbit - 64'd1) t = lowbit - 64'd1;
      e = t + 64'd1;
      visited = remaining ^ (remaining - 64'd1);
      sl.slice_offset   = base + s;
      sl.slice_count    = (e > s) ? e - s : '0;
      sl.cover_start    = CoordW'(s << p);
      sl.cover_end      = (e + 64'd1) << p;
      sl.span_size      = 64'd2 << p;
      sl.empty_res      = 1'b0;
      sl.depth_overflow = ovf;
      sl.last           = (k == DepthCap - 1) || ((mask_cfg & ~visited) == '0);
      slices_due.push_back(sl);
    end
  endfunction

  function automatic query_t random_query();
    query_t      q;
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(7))
      0: begin
        q.query_start = a[CoordW-1:0];
        q.query_end   = b[CoordW-1:0];
      end
      1: begin
        q.query_end   = CoordW'(a >> $urandom_range(63));
        q.query_start = q.query_end + CoordW'(b >> $urandom_range(20, 63)) + 1'b1;
      end
      default: begin
        q.query_start = CoordW'(a >> $urandom_range(63));
        q.query_end   = q.query_start + CoordW'(b >> $urandom_range(63));
      end
    endcase
    return q;
  endfunction

  function automatic logic [63:0] random_mask();
    logic [63:0] m;
    int unsigned bits_wanted, top;
    m = '0;
    case ($urandom_range(9))
      0:       bits_wanted = 0;
      1:       bits_wanted = $urandom_range(9, 20);
      default: bits_wanted = $urandom_range(1, 8);
    endcase
    top = ($urandom_range(2) == 0 || bits_wanted > 8) ? 63 : 15;
    while ($countones(m) < bits_wanted) m[$urandom_range(top)] = 1'b1;
    return m;
  endfunction

  function automatic logic [63:0] random_pitch();
    logic [63:0] pt;
    for (int i = 0; i < 8; i++) begin
      pt[8*i +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(40));
    end
    return pt;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    end
  endtask

  task automatic write_reg(hbrq_reg_e idx, logic [63:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == RegDepthCountMask) mask_cfg = value;
    if (idx == RegPitchTable) pitch_cfg = value;
  endtask

  task automatic wait_drained();
    while (pending_queries.size() != 0 || query_if.valid || slices_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // registers change only with the pipeline empty and settled
  task automatic configure(logic [63:0] mask, logic [63:0] pitch);
    wait_drained();
    repeat (PauseCycles) @(posedge clk);
    write_reg(RegDepthCountMask, mask);
    write_reg(RegPitchTable, pitch);
    repeat (PauseCycles) @(posedge clk);
    settings_used++;
  endtask

  task automatic set_idling(idle_mode_e mode);
    @(negedge clk);
    case (mode)
      IdleNone: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IdleSender: begin
        send_idle_pct  = IdlePct;
        recv_stall_pct = 0;
      end
      IdleReceiver: begin
        send_idle_pct  = 0;
        recv_stall_pct = IdlePct;
      end
      default: begin
        send_idle_pct  = BothPct;
        recv_stall_pct = BothPct;
      end
    endcase
  endtask

  task automatic push_query(logic [CoordW-1:0] q_start, logic [CoordW-1:0] q_end);
    query_t q;
    q.query_start = q_start;
    q.query_end   = q_end;
    @(negedge clk);
    pending_queries.push_back(q);
  endtask

  task automatic push_random(int unsigned n);
    @(negedge clk);
    repeat (n) pending_queries.push_back(random_query());
  endtask

  // query driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      query_if.valid <= 1'b0;
    end else begin
      if (query_if.valid && query_if.ready) begin
        predict_slices(query_if.query_start, query_if.query_end);
        queries_taken++;
      end
      if (!query_if.valid || query_if.ready) begin
        if (pending_queries.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_queries.pop_front();
          query_if.valid       <= 1'b1;
          query_if.query_start <= next_item.query_start;
          query_if.query_end   <= next_item.query_end;
        end else begin
          query_if.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, held low during a hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) begin
      got_slice.slice_offset   = result_if.slice_offset;
      got_slice.slice_count    = result_if.slice_count;
      got_slice.cover_start    = result_if.cover_start;
      got_slice.cover_end      = result_if.cover_end;
      got_slice.span_size      = result_if.span_size;
      got_slice.empty_res      = result_if.empty_res;
      got_slice.depth_overflow = result_if.depth_overflow;
      got_slice.last           = result_if.last;
      if (slices_due.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: unexpected slice, expected none actual %p", $time, got_slice);
        end
      end else begin
        want_slice = slices_due.pop_front();
        check_field("slice_offset", want_slice.slice_offset, got_slice.slice_offset);
        check_field("slice_count", want_slice.slice_count, got_slice.slice_count);
        check_field("cover_start", 64'(want_slice.cover_start), 64'(got_slice.cover_start));
        check_field("cover_end", want_slice.cover_end, got_slice.cover_end);
        check_field("span_size", want_slice.span_size, got_slice.span_size);
        check_field("empty_res", 64'(want_slice.empty_res), 64'(got_slice.empty_res));
        check_field("depth_overflow", 64'(want_slice.depth_overflow),
                    64'(got_slice.depth_overflow));
        check_field("last", 64'(want_slice.last), 64'(got_slice.last));
      end
      slices_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("run stopped after %0d cycles with %0d slices outstanding",
               cycle_count, slices_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n                = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = RegDepthCountMask;
    cfg_if.data          = '0;
    query_if.valid       = 1'b0;
    query_if.query_start = '0;
    query_if.query_end   = '0;
    result_if.ready      = 1'b0;
    mask_cfg             = DepthMaskReset;
    pitch_cfg            = PitchTableReset;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    hold_cycles          = 0;
    errors               = 0;
    queries_taken        = 0;
    slices_checked       = 0;
    settings_used        = 1;
    cycle_count          = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: one depth of one bin, pitch exponent 62
    set_idling(IdleNone);
    push_query('0, '0);
    push_query('1, '1);
    push_query('0, '1);
    push_query('1, '0);
    push_query(63'h4000_0000_0000_0000, 63'h3FFF_FFFF_FFFF_FFFF);
    push_query(63'd5, 63'd5);

    // zero mask gives a single empty slice
    configure('0, '0);
    push_query('0, '1);
    push_query('1, '0);
    push_query(63'd7, 63'd9);

    // all depths with out-of-range exponents: overflow and zero shifts
    configure('1, '1);
    push_query('1, '1);
    push_query(63'd3, 63'd100);
    push_query('0, '0);

    // top depth only, pitch zero: widest clamp
    configure(64'h8000_0000_0000_0000, '0);
    push_query('1, '1);
    push_query('0, '1);
    push_query(63'd1, 63'd0);

    // nine depths at exponent 63: span wraps to zero
    configure(64'h8000_0000_0000_00FF, 64'h3F3F_3F3F_3F3F_3F3F);
    push_query('1, '1);
    push_query(63'd12, 63'd4000);
    push_query('0, '0);

    // eight depths while the receiver holds off and the input backs up
    configure(64'h0000_0000_0000_00FF, 64'h0706_0504_0302_0100);
    set_idling(IdleNone);
    @(negedge clk);
    hold_cycles = 300;
    push_random(40);

    for (int i = 0; i < 8; i++) begin
      configure(random_mask(), random_pitch());
      set_idling(idle_mode_e'(i % 4));
      push_random(20);
    end

    wait_drained();
    repeat (PauseCycles) @(posedge clk);
    $display("covered %0d queries and %0d result slices over %0d mask/pitch settings",
             queries_taken, slices_checked, settings_used);
    $display("including zero, overflowing and top-bit masks with a receiver hold-off");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hbrq_pkg.sv
rtl/hbrq_ifs.sv
rtl/hierarchical_bin_range_query_unit.sv
tb/testbench.sv
